[design/rna_pkg.sv]
// Shared types, constants and helper functions for the radix number to ASCII block.
// Depends on nothing; used by rna_divider, radix_number_to_ascii and rna_checker.
`default_nettype none

package rna_pkg;

   // Field widths fixed by the interface.
   localparam int INPUT_W  = 32;
   localparam int RADIX_W  = 6;
   localparam int DIGIT_W  = 6;
   localparam int CHAR_W   = 7;

   // Default width of the number that is converted.
   localparam int DEFAULT_VALUE_BITS = 32;

   // Legal range of the base and its value after reset.
   localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
   localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
   localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;

   // Character codes and the point where letters take over from numerals.
   localparam logic [CHAR_W-1:0]  CHAR_ZERO      = 7'h30;
   localparam logic [CHAR_W-1:0]  CHAR_LETTER_A  = 7'h41;
   localparam logic [CHAR_W-1:0]  CHAR_NINE      = 7'h39;
   localparam logic [CHAR_W-1:0]  CHAR_LETTER_Z  = 7'h5A;
   localparam logic [DIGIT_W-1:0] DECIMAL_DIGITS = 6'd10;

   // Sequencer states of the top level.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_EMIT
   } rna_state_type;

   // Maps a digit value 0..35 to '0'..'9' and 'A'..'Z'.
   function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] digit);
      logic [CHAR_W-1:0] result;
      if (digit < DECIMAL_DIGITS) begin
         result = CHAR_ZERO + {1'b0, digit};
      end else begin
         result = CHAR_LETTER_A + {1'b0, digit - DECIMAL_DIGITS};
      end
      return result;
   endfunction

   // Forces a written base into the legal range.
   function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] value);
      logic [RADIX_W-1:0] result;
      if (value < RADIX_MIN) begin
         result = RADIX_MIN;
      end else if (value > RADIX_MAX) begin
         result = RADIX_MAX;
      end else begin
         result = value;
      end
      return result;
   endfunction

endpackage

`default_nettype wire

[design/rna_divider.sv]
// Bit-serial restoring divider: one quotient bit per cycle, quotient and remainder.
// Depends on rna_pkg for the base and digit widths.
`default_nettype none

module rna_divider
   import rna_pkg::*;
#(
   parameter int VALUE_BITS = DEFAULT_VALUE_BITS
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  load,
   input  wire logic [VALUE_BITS-1:0] dividend,
   input  wire logic [RADIX_W-1:0]    divisor,
   output logic                       done,
   output logic [VALUE_BITS-1:0]      quotient,
   output logic [DIGIT_W-1:0]         remainder
);

   localparam int CNT_W = $clog2(VALUE_BITS);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(VALUE_BITS - 1);

   logic                  active_ff, active_in;
   logic                  done_ff, done_in;
   logic [CNT_W-1:0]      step_ff, step_in;
   logic [VALUE_BITS-1:0] quot_ff, quot_in;
   logic [DIGIT_W-1:0]    rem_ff, rem_in;

   logic [DIGIT_W:0]      trial;
   logic [DIGIT_W:0]      diff;
   logic                  fits;

   // One restoring step: bring down the next dividend bit and try the subtraction.
   always_comb begin
      trial = {rem_ff, quot_ff[VALUE_BITS-1]};
      diff  = trial - {1'b0, divisor};
      fits  = (trial >= {1'b0, divisor});
   end

   // Next values of the shift registers and the step counter.
   always_comb begin
      active_in = active_ff;
      done_in   = 1'b0;
      step_in   = step_ff;
      quot_in   = quot_ff;
      rem_in    = rem_ff;
      if (load) begin
         active_in = 1'b1;
         step_in   = LAST_STEP;
         quot_in   = dividend;
         rem_in    = '0;
      end else if (active_ff) begin
         quot_in = {quot_ff[VALUE_BITS-2:0], fits};
         rem_in  = fits ? diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
         step_in = step_ff - 1'b1;
         if (step_ff == '0) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
      end
   end

   // Data registers.
   always_ff @(posedge clock) begin
      step_ff <= step_in;
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
   end

   assign done      = done_ff;
   assign quotient  = quot_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

[design/radix_number_to_ascii.sv]
// Top level of the number to ASCII converter: sequencer, digit stack and output register.
// Depends on rna_pkg and rna_divider.
//
// Usage:
//   Pulse start with req_number_value while busy is low; the item is taken at that edge.
//   The block divides the number repeatedly by the base held in the radix register,
//   pushing each remainder onto a digit stack, then pops the stack so that characters
//   leave most significant first. Each character appears on rsp_char_code for exactly
//   one cycle with rsp_valid high; rsp_is_last marks the least significant character.
//   The receiver cannot stall, and characters of one item come in consecutive cycles.
//   Every digit takes a full bit-serial division in the divider before the next one starts,
//   and busy stays high until the last character of an item has left, so the next item
//   is taken only after that.
//   Zero gives the single character '0'.
//   Configuration: csr_write_enable with csr_write_data sets the base; values below 2
//   become 2, values above 36 become 36. Write it only while busy is low.
//   Reset returns the sequencer to idle, drops any pending output and sets the base
//   to 10. The digit stack needs no clearing, since only written entries are read.
`default_nettype none

module radix_number_to_ascii
   import rna_pkg::*;
#(
   parameter int VALUE_BITS = DEFAULT_VALUE_BITS
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic [INPUT_W-1:0] req_number_value,
   input  wire logic               csr_write_enable,
   input  wire logic [RADIX_W-1:0] csr_write_data,
   output logic                    rsp_valid,
   output logic [CHAR_W-1:0]       rsp_char_code,
   output logic                    rsp_is_last
);

   localparam int ADDR_W = $clog2(VALUE_BITS);

   rna_state_type         state_ff, state_in;
   logic [RADIX_W-1:0]    radix_ff;
   logic [ADDR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [ADDR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic                  rd_valid_ff;
   logic                  rd_last_ff;
   logic [DIGIT_W-1:0]    rd_data_ff;
   logic [DIGIT_W-1:0]    digit_mem [VALUE_BITS];

   logic [VALUE_BITS-1:0] number_ext;
   logic [VALUE_BITS-1:0] div_dividend;
   logic                  div_load;
   logic                  div_done;
   logic [VALUE_BITS-1:0] div_quotient;
   logic [DIGIT_W-1:0]    div_remainder;
   logic                  quotient_zero;
   logic                  push;
   logic                  issue_read;

   // Bring the input to the working width.
   generate
      if (VALUE_BITS > INPUT_W) begin : g_widen
         assign number_ext = {{(VALUE_BITS - INPUT_W){1'b0}}, req_number_value};
      end else begin : g_narrow
         assign number_ext = req_number_value[VALUE_BITS-1:0];
      end
   endgenerate

   assign quotient_zero = (div_quotient == '0);

   // Next state of the sequencer.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start && !busy) begin
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (div_done && quotient_zero) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (rd_ptr_ff == '0) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs: divider loads, stack pushes and stack reads.
   always_comb begin
      div_load     = 1'b0;
      div_dividend = div_quotient;
      push         = 1'b0;
      issue_read   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            div_dividend = number_ext;
            div_load     = start && !busy;
         end
         ST_DIVIDE: begin
            push     = div_done;
            div_load = div_done && !quotient_zero;
         end
         ST_EMIT: begin
            issue_read = 1'b1;
         end
         default: begin
            div_load = 1'b0;
         end
      endcase
   end

   // Stack pointers: write grows per digit, read walks back from the top.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (state_ff == ST_IDLE) begin
         wr_ptr_in = '0;
      end else if (push && !quotient_zero) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (push && quotient_zero) begin
         rd_ptr_in = wr_ptr_ff;
      end else if (issue_read) begin
         rd_ptr_in = rd_ptr_ff - 1'b1;
      end
   end

   // Control registers and the base register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         radix_ff    <= RADIX_RESET;
         rd_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         rd_valid_ff <= issue_read;
         if (csr_write_enable) begin
            radix_ff <= clamp_radix(csr_write_data);
         end
      end
   end

   // Pointers and the end marker.
   always_ff @(posedge clock) begin
      wr_ptr_ff  <= wr_ptr_in;
      rd_ptr_ff  <= rd_ptr_in;
      rd_last_ff <= (rd_ptr_ff == '0);
   end

   // Digit stack write port.
   always_ff @(posedge clock) begin
      if (push) begin
         digit_mem[wr_ptr_ff] <= div_remainder;
      end
   end

   // Digit stack read port with registered data.
   always_ff @(posedge clock) begin
      if (issue_read) begin
         rd_data_ff <= digit_mem[rd_ptr_ff];
      end
   end

   rna_divider #(
      .VALUE_BITS (VALUE_BITS)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .load      (div_load),
      .dividend  (div_dividend),
      .divisor   (radix_ff),
      .done      (div_done),
      .quotient  (div_quotient),
      .remainder (div_remainder)
   );

   // Result ports and the handshake status.
   assign busy          = (state_ff != ST_IDLE) || rd_valid_ff;
   assign rsp_valid     = rd_valid_ff;
   assign rsp_char_code = digit_to_char(rd_data_ff);
   assign rsp_is_last   = rd_last_ff;

endmodule

`default_nettype wire

[design/rna_checker.sv]
// Port-level checks on the number to ASCII converter, attached by a bind statement.
// Depends on rna_pkg and on the port list of radix_number_to_ascii.
`default_nettype none

module rna_checker
   import rna_pkg::*;
(
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              start,
   input wire logic              busy,
   input wire logic              rsp_valid,
   input wire logic [CHAR_W-1:0] rsp_char_code,
   input wire logic              rsp_is_last
);

   // An accepted item makes the block busy in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted item did not raise busy");

   // Characters only appear while an item is in flight.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("character delivered while idle");

   // Characters of one item come in consecutive cycles up to the end marker.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_last |=> rsp_valid)
      else $error("gap inside a character string");

   // Nothing follows the end marker in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_last |=> !rsp_valid)
      else $error("character after the end marker");

   // Every character is a numeral or an upper-case letter.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_char_code >= CHAR_ZERO) && (rsp_char_code <= CHAR_NINE)) ||
                    ((rsp_char_code >= CHAR_LETTER_A) && (rsp_char_code <= CHAR_LETTER_Z)))
      else $error("character code outside the digit set");

endmodule

bind radix_number_to_ascii rna_checker u_rna_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .rsp_valid     (rsp_valid),
   .rsp_char_code (rsp_char_code),
   .rsp_is_last   (rsp_is_last)
);

`default_nettype wire
